// ===== hdl/pse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and functions of the PNG stored stream encoder.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int DIM_W = 11;
  localparam logic [DIM_W-1:0] MAX_WIDTH  = 11'd1024;
  localparam logic [DIM_W-1:0] MAX_HEIGHT = 11'd1024;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [15:0] ADLER_MOD  = 16'd65521;
  localparam logic [15:0] STORED_MAX = 16'hFFFF;
  localparam logic [7:0]  ZLIB_CMF   = 8'h78;
  localparam logic [7:0]  ZLIB_FLG   = 8'h01;
  localparam logic [7:0]  SIG_FIRST  = 8'h89;

  localparam logic [5:0] HDR_LAST  = 6'd42;
  localparam logic [5:0] TAIL_LAST = 6'd19;
  localparam logic [5:0] BLK_LAST  = 6'd4;

  localparam logic [1:0] SLOT_FILTER = 2'd0;
  localparam logic [1:0] SLOT_RED    = 2'd1;
  localparam logic [1:0] SLOT_GREEN  = 2'd2;
  localparam logic [1:0] SLOT_BLUE   = 2'd3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_PIX,
    ST_TAIL
  } state_t;

  typedef struct packed {
    logic        is_pixel;
    logic [23:0] rgb;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

  function automatic logic [DIM_W-1:0] dim_clamp(logic [DIM_W-1:0] v,
                                                 logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > vmax) begin
      r = vmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pse_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_in_if
// Command channel: start frame or one pixel.
// ----------------------------------------------------------------------------
interface pse_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] pixel_argb;

  modport source (output valid, command, pixel_argb, input ready);
  modport sink   (input valid, command, pixel_argb, output ready);
endinterface
`default_nettype wire

// ===== hdl/pse_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_out_if
// Byte stream channel of the PNG file.
// ----------------------------------------------------------------------------
interface pse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       file_last;

  modport source (output valid, out_byte, run_last, file_last, input ready);
  modport sink   (input valid, out_byte, run_last, file_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/pse_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_front
// Accepts command transactions, classifies them and queues them (2 deep).
// ----------------------------------------------------------------------------
module pse_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            command,
  input  wire logic [31:0]     pixel_argb,
  output pse_pkg::queue_t      q,
  input  wire logic            q_pop
);
  import pse_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  item_t      item_in;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;

  assign item_in.is_pixel = command;
  assign item_in.rgb      = pixel_argb[23:0];

  assign q.valid = (count_r != 2'd0);
  assign q.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pse_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pse_back
// Byte sequencer: headers, stored blocks, raw bytes, checksums and trailer.
// ----------------------------------------------------------------------------
module pse_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire pse_pkg::queue_t         q,
  output logic                         q_pop,
  input  wire logic [pse_pkg::DIM_W-1:0] width_cfg,
  input  wire logic [pse_pkg::DIM_W-1:0] height_cfg,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   out_byte,
  output logic                         run_last,
  output logic                         file_last
);
  import pse_pkg::*;

  state_t            state_r, state_nxt;
  logic [5:0]        idx_r;
  logic [1:0]        slot_r;
  logic [23:0]       rgb_r;
  logic [DIM_W-1:0]  wc_r, hc_r;
  logic [21:0]       raw_r, zlen_r;
  logic [31:0]       crc_r;
  logic [15:0]       adl_lo_r, adl_hi_r;
  logic [DIM_W-1:0]  col_r;
  logic [15:0]       blk_left_r;
  logic [21:0]       raw_left_r;
  logic              frame_open_r;
  logic              out_valid_r, run_last_r, file_last_r;
  logic [7:0]        out_byte_r;

  logic              adv, pop_item, start_hdr, start_pix, drop, go;
  logic              in_hdr, in_pix, in_tail;
  logic [5:0]        cur_idx;
  logic [1:0]        cur_slot;
  logic [23:0]       cur_rgb;
  logic [7:0]        byte_val;
  logic              byte_crc, crc_restart, is_last, file_end;
  logic              blk_needed, raw_end;
  logic [15:0]       blk_n;
  logic              blk_final;
  logic [31:0]       crc_inv;
  logic [7:0]        raw_val;
  logic [16:0]       adl_a, adl_b;
  logic [15:0]       adl_a16, adl_b16;
  logic [DIM_W-1:0]  col_inc, col_nxt, w_now;
  logic [11:0]       row_bytes;
  logic [16:0]       blk_sum;
  logic [1:0]        blk_extra;
  logic [6:0]        blocks;

  assign adv       = !out_valid_r || out_ready;
  assign pop_item  = (state_r == ST_IDLE) && q.valid;
  assign start_hdr = pop_item && !q.item.is_pixel;
  assign start_pix = pop_item && q.item.is_pixel && frame_open_r;
  assign drop      = pop_item && q.item.is_pixel && !frame_open_r;
  assign q_pop     = drop || ((start_hdr || start_pix) && adv);

  assign in_hdr  = start_hdr || (state_r == ST_HDR);
  assign in_pix  = start_pix || (state_r == ST_PIX);
  assign in_tail = (state_r == ST_TAIL);
  assign go      = adv && (in_hdr || in_pix || in_tail);

  assign cur_idx  = pop_item ? 6'd0 : idx_r;
  assign cur_slot = pop_item ? ((col_r == '0) ? SLOT_FILTER : SLOT_RED) : slot_r;
  assign cur_rgb  = pop_item ? q.item.rgb : rgb_r;

  assign crc_inv    = ~crc_r;
  assign blk_needed = (blk_left_r == 16'd0);
  assign blk_final  = (raw_left_r[21:16] == 6'd0);
  assign blk_n      = blk_final ? raw_left_r[15:0] : STORED_MAX;
  assign raw_end    = (raw_left_r == 22'd1);

  always_comb begin
    unique case (cur_slot)
      SLOT_FILTER: raw_val = 8'd0;
      SLOT_RED:    raw_val = cur_rgb[23:16];
      SLOT_GREEN:  raw_val = cur_rgb[15:8];
      SLOT_BLUE:   raw_val = cur_rgb[7:0];
      default:     raw_val = 8'd0;
    endcase
  end

  // adler update
  always_comb begin
    adl_a   = {1'b0, adl_lo_r} + {9'b0, raw_val};
    adl_a16 = (adl_a >= {1'b0, ADLER_MOD}) ? 16'(adl_a - {1'b0, ADLER_MOD}) : adl_a[15:0];
    adl_b   = {1'b0, adl_hi_r} + {1'b0, adl_a16};
    adl_b16 = (adl_b >= {1'b0, ADLER_MOD}) ? 16'(adl_b - {1'b0, ADLER_MOD}) : adl_b[15:0];
  end

  assign w_now   = dim_clamp(width_cfg, MAX_WIDTH);
  assign col_inc = col_r + DIM_W'(1);
  assign col_nxt = (col_inc >= w_now) ? '0 : col_inc;

  // byte selection
  always_comb begin
    byte_val    = 8'd0;
    byte_crc    = 1'b0;
    crc_restart = 1'b0;
    is_last     = 1'b0;
    file_end    = 1'b0;
    if (in_hdr) begin
      case (cur_idx)
        6'd0:  byte_val = SIG_FIRST;
        6'd1:  byte_val = 8'h50;
        6'd2:  byte_val = 8'h4E;
        6'd3:  byte_val = 8'h47;
        6'd4:  byte_val = 8'h0D;
        6'd5:  byte_val = 8'h0A;
        6'd6:  byte_val = 8'h1A;
        6'd7:  byte_val = 8'h0A;
        6'd11: byte_val = 8'd13;
        6'd12: begin byte_val = 8'h49; byte_crc = 1'b1; crc_restart = 1'b1; end
        6'd13: begin byte_val = 8'h48; byte_crc = 1'b1; end
        6'd14: begin byte_val = 8'h44; byte_crc = 1'b1; end
        6'd15: begin byte_val = 8'h52; byte_crc = 1'b1; end
        6'd16, 6'd17, 6'd20, 6'd21, 6'd26, 6'd27, 6'd28: begin
          byte_crc = 1'b1;
        end
        6'd18: begin byte_val = {5'b0, wc_r[10:8]}; byte_crc = 1'b1; end
        6'd19: begin byte_val = wc_r[7:0]; byte_crc = 1'b1; end
        6'd22: begin byte_val = {5'b0, hc_r[10:8]}; byte_crc = 1'b1; end
        6'd23: begin byte_val = hc_r[7:0]; byte_crc = 1'b1; end
        6'd24: begin byte_val = 8'd8; byte_crc = 1'b1; end
        6'd25: begin byte_val = 8'd2; byte_crc = 1'b1; end
        6'd29: byte_val = crc_inv[31:24];
        6'd30: byte_val = crc_inv[23:16];
        6'd31: byte_val = crc_inv[15:8];
        6'd32: byte_val = crc_inv[7:0];
        6'd34: byte_val = {2'b0, zlen_r[21:16]};
        6'd35: byte_val = zlen_r[15:8];
        6'd36: byte_val = zlen_r[7:0];
        6'd37: begin byte_val = 8'h49; byte_crc = 1'b1; crc_restart = 1'b1; end
        6'd38: begin byte_val = 8'h44; byte_crc = 1'b1; end
        6'd39: begin byte_val = 8'h41; byte_crc = 1'b1; end
        6'd40: begin byte_val = 8'h54; byte_crc = 1'b1; end
        6'd41: begin byte_val = ZLIB_CMF; byte_crc = 1'b1; end
        6'd42: begin byte_val = ZLIB_FLG; byte_crc = 1'b1; is_last = 1'b1; end
        default: byte_val = 8'd0;
      endcase
    end else if (in_pix) begin
      byte_crc = 1'b1;
      if (blk_needed) begin
        case (cur_idx[2:0])
          3'd0:    byte_val = {7'b0, blk_final};
          3'd1:    byte_val = blk_n[7:0];
          3'd2:    byte_val = blk_n[15:8];
          3'd3:    byte_val = ~blk_n[7:0];
          default: byte_val = ~blk_n[15:8];
        endcase
      end else begin
        byte_val = raw_val;
        is_last  = (cur_slot == SLOT_BLUE) && !raw_end;
      end
    end else if (in_tail) begin
      case (cur_idx)
        6'd0:  begin byte_val = adl_hi_r[15:8]; byte_crc = 1'b1; end
        6'd1:  begin byte_val = adl_hi_r[7:0];  byte_crc = 1'b1; end
        6'd2:  begin byte_val = adl_lo_r[15:8]; byte_crc = 1'b1; end
        6'd3:  begin byte_val = adl_lo_r[7:0];  byte_crc = 1'b1; end
        6'd4,  6'd16: byte_val = crc_inv[31:24];
        6'd5,  6'd17: byte_val = crc_inv[23:16];
        6'd6,  6'd18: byte_val = crc_inv[15:8];
        6'd7:  byte_val = crc_inv[7:0];
        6'd12: begin byte_val = 8'h49; byte_crc = 1'b1; crc_restart = 1'b1; end
        6'd13: begin byte_val = 8'h45; byte_crc = 1'b1; end
        6'd14: begin byte_val = 8'h4E; byte_crc = 1'b1; end
        6'd15: begin byte_val = 8'h44; byte_crc = 1'b1; end
        6'd19: begin byte_val = crc_inv[7:0]; is_last = 1'b1; file_end = 1'b1; end
        default: byte_val = 8'd0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_hdr && adv) begin
          state_nxt = ST_HDR;
        end else if (start_pix && adv) begin
          state_nxt = (!blk_needed && raw_end) ? ST_TAIL :
                      (is_last ? ST_IDLE : ST_PIX);
        end
      end
      ST_HDR: begin
        if (go && (idx_r == HDR_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PIX: begin
        if (go && !blk_needed) begin
          if (raw_end) begin
            state_nxt = ST_TAIL;
          end else if (slot_r == SLOT_BLUE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (go && (idx_r == TAIL_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign row_bytes = 12'({1'b0, wc_r} + {wc_r, 1'b0}) + 12'd1;
  assign blk_sum   = {11'b0, raw_r[21:16]} + {1'b0, raw_r[15:0]};
  assign blk_extra = (blk_sum == 17'd0) ? 2'd0 :
                     ((blk_sum > {1'b0, STORED_MAX}) ? 2'd2 : 2'd1);
  assign blocks    = {1'b0, raw_r[21:16]} + {5'b0, blk_extra};

  always_ff @(posedge clk) begin
    raw_r  <= {10'b0, row_bytes} * {11'b0, hc_r};
    zlen_r <= raw_r + 22'd6 + ({15'b0, blocks} * 22'd5);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= 6'd0;
      slot_r       <= SLOT_FILTER;
      frame_open_r <= 1'b0;
      crc_r        <= '1;
      adl_lo_r     <= 16'd1;
      adl_hi_r     <= 16'd0;
      col_r        <= '0;
      blk_left_r   <= 16'd0;
      raw_left_r   <= 22'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= go;
      end
      if (start_hdr && adv) begin
        frame_open_r <= 1'b1;
        adl_lo_r     <= 16'd1;
        adl_hi_r     <= 16'd0;
        col_r        <= '0;
        blk_left_r   <= 16'd0;
      end
      if (go && byte_crc) begin
        crc_r <= crc_byte(crc_restart ? '1 : crc_r, byte_val);
      end
      if (go) begin
        if (in_hdr) begin
          idx_r <= (cur_idx == HDR_LAST) ? 6'd0 : cur_idx + 6'd1;
          if (cur_idx == HDR_LAST) begin
            raw_left_r <= raw_r;
          end
        end else if (in_pix) begin
          slot_r <= cur_slot;
          if (blk_needed) begin
            if (cur_idx == BLK_LAST) begin
              idx_r      <= 6'd0;
              blk_left_r <= blk_n;
            end else begin
              idx_r <= cur_idx + 6'd1;
            end
          end else begin
            idx_r      <= 6'd0;
            adl_lo_r   <= adl_a16;
            adl_hi_r   <= adl_b16;
            blk_left_r <= blk_left_r - 16'd1;
            raw_left_r <= raw_left_r - 22'd1;
            slot_r     <= cur_slot + 2'd1;
            if (raw_end || (cur_slot == SLOT_BLUE)) begin
              col_r <= col_nxt;
            end
          end
        end else begin
          idx_r <= (cur_idx == TAIL_LAST) ? 6'd0 : cur_idx + 6'd1;
          if (cur_idx == TAIL_LAST) begin
            frame_open_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_hdr && adv) begin
      wc_r <= dim_clamp(width_cfg, MAX_WIDTH);
      hc_r <= dim_clamp(height_cfg, MAX_HEIGHT);
    end
    if (start_pix && adv) begin
      rgb_r <= q.item.rgb;
    end
    if (go) begin
      out_byte_r  <= byte_val;
      run_last_r  <= is_last;
      file_last_r <= file_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign run_last  = run_last_r;
  assign file_last = file_last_r;

endmodule
`default_nettype wire

// ===== hdl/png_stored_stream_encoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// png_stored_stream_encoder
// Streams an 8-bit RGB PNG file with stored deflate blocks.
// ----------------------------------------------------------------------------
// One byte leaves per cycle through the output register unless out_ready
// stalls it. A start yields 43 bytes, a pixel 3 or 4 (filter byte on a row
// start), plus 5 for each stored-block header and 20 for the checksum and
// IEND trailer after the last pixel. A two-deep command queue lets commands
// arrive while the sequencer is busy.
module png_stored_stream_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pse_in_if.sink           in_ch,
  pse_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pse_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  queue_t           q;
  logic             q_pop;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd256;
      height_r <= 11'd240;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        default:    width_r  <= width_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT) ? {21'b0, height_r} : {21'b0, width_r};

  pse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .command    (in_ch.command),
    .pixel_argb (in_ch.pixel_argb),
    .q          (q),
    .q_pop      (q_pop)
  );

  pse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q          (q),
    .q_pop      (q_pop),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .run_last   (out_ch.run_last),
    .file_last  (out_ch.file_last)
  );

  a_file_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.file_last |-> out_ch.run_last)
    else $error("file_last without run_last");

  a_full_queue_offers: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q.valid)
    else $error("queue full but nothing offered");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q.valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== bench/png_stored_stream_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// png_stored_stream_encoder_tb
// Drives start and pixel commands into the PNG stream encoder under several
// frame sizes and random backpressure. A behavioral byte predictor builds the
// expected file stream, and every output byte is checked against it.
// ----------------------------------------------------------------------------
module png_stored_stream_encoder_tb;
  import pse_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } png_byte_t;

  typedef struct {
    logic        cmd;
    logic [31:0] argb;
    int          first_byte;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pse_in_if in_ch ();
  pse_out_if out_ch ();

  png_stored_stream_encoder u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.pixel_argb = '0;
    out_ch.ready = 1'b0;
  end

  png_byte_t png_bytes_q[$];
  int        fail_count = 0;
  int        byte_count = 0;
  int        frame_count = 0;
  int        idle_cycles = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;

  // predictor state
  logic [10:0] pr_width = 11'd256;
  logic [10:0] pr_height = 11'd240;
  logic        pr_open = 1'b0;
  logic [31:0] pr_crc = '1;
  logic [15:0] pr_adler_lo = 16'd1;
  logic [15:0] pr_adler_hi = '0;
  int unsigned pr_col = 0;
  int unsigned pr_block_left = 0;
  int unsigned pr_raw_left = 0;
  int          pr_step_bytes = 0;

  function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'b0, b};
    for (int k = 0; k < 8; k++) x = x[0] ? (32'hEDB88320 ^ (x >> 1)) : (x >> 1);
    return x;
  endfunction

  function automatic int unsigned dim_used(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 11'd1024) return 1024;
    return v;
  endfunction

  function automatic void push_byte(logic [7:0] b, bit in_crc);
    png_byte_t e;
    if (in_crc) pr_crc = crc_update(pr_crc, b);
    e.data = b;
    e.run_end = 1'b0;
    e.file_end = 1'b0;
    png_bytes_q.push_back(e);
    pr_step_bytes++;
  endfunction

  function automatic void push_word(logic [31:0] v, bit in_crc);
    for (int i = 3; i >= 0; i--) push_byte(v[8*i +: 8], in_crc);
  endfunction

  function automatic void push_raw(logic [7:0] v);
    int unsigned n;
    logic [15:0] nn;
    int unsigned a;
    int unsigned s;
    if (pr_raw_left == 0) return;
    if (pr_block_left == 0) begin
      n = (pr_raw_left > 65535) ? 65535 : pr_raw_left;
      nn = ~n[15:0];
      push_byte((n == pr_raw_left) ? 8'd1 : 8'd0, 1);
      push_byte(n[7:0], 1);
      push_byte(n[15:8], 1);
      push_byte(nn[7:0], 1);
      push_byte(nn[15:8], 1);
      pr_block_left = n;
    end
    push_byte(v, 1);
    a = pr_adler_lo + v;
    if (a >= 65521) a -= 65521;
    s = pr_adler_hi + a;
    if (s >= 65521) s -= 65521;
    pr_adler_lo = a;
    pr_adler_hi = s;
    pr_block_left--;
    pr_raw_left--;
  endfunction

  function automatic void predict_png_bytes(logic cmd, logic [31:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned raw;
    bit ended;
    logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    ended = 0;
    pr_step_bytes = 0;
    if (cmd == 1'b0) begin
      w = dim_used(pr_width);
      h = dim_used(pr_height);
      raw = (3 * w + 1) * h;
      foreach (sig[i]) push_byte(sig[i], 0);
      push_word(32'd13, 0);
      pr_crc = '1;
      push_word("IHDR", 1);
      push_word(w, 1);
      push_word(h, 1);
      push_byte(8'd8, 1);
      push_byte(8'd2, 1);
      push_byte(8'd0, 1);
      push_byte(8'd0, 1);
      push_byte(8'd0, 1);
      push_word(~pr_crc, 0);
      push_word(2 + raw + 5 * ((raw + 65534) / 65535) + 4, 0);
      pr_crc = '1;
      push_word("IDAT", 1);
      push_byte(8'h78, 1);
      push_byte(8'h01, 1);
      pr_adler_lo = 16'd1;
      pr_adler_hi = '0;
      pr_col = 0;
      pr_block_left = 0;
      pr_raw_left = raw;
      pr_open = 1'b1;
    end else begin
      if (!pr_open) return;
      w = dim_used(pr_width);
      if (pr_col == 0) push_raw(8'd0);
      push_raw(px[23:16]);
      push_raw(px[15:8]);
      push_raw(px[7:0]);
      pr_col++;
      if (pr_col >= w) pr_col = 0;
      if (pr_raw_left == 0) begin
        push_word({pr_adler_hi, pr_adler_lo}, 1);
        push_word(~pr_crc, 0);
        push_word(32'd0, 0);
        pr_crc = '1;
        push_word("IEND", 1);
        push_word(~pr_crc, 0);
        pr_crc = '1;
        pr_open = 1'b0;
        ended = 1;
      end
    end
    if (pr_step_bytes > 0) begin
      png_bytes_q[$].run_end = 1'b1;
      if (ended) png_bytes_q[$].file_end = 1'b1;
    end
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    png_byte_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        byte_count++;
        if (png_bytes_q.size() == 0) begin
          $error("unexpected byte %h", out_ch.out_byte);
          fail_count++;
        end else begin
          e = png_bytes_q.pop_front();
          if (out_ch.out_byte !== e.data) begin
            $error("out_byte expected %h actual %h", e.data, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.run_last !== e.run_end) begin
            $error("run_last expected %b actual %b", e.run_end, out_ch.run_last);
            fail_count++;
          end
          if (out_ch.file_last !== e.file_end) begin
            $error("file_last expected %b actual %b", e.file_end, out_ch.file_last);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_cmd(logic cmd, logic [31:0] px, int first_byte);
    int skip;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pixel_argb <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    skip = png_bytes_q.size();
    predict_png_bytes(cmd, px);
    if (first_byte >= 0 && png_bytes_q.size() > skip &&
        png_bytes_q[skip].data !== first_byte[7:0]) begin
      $error("first byte expected %h predicted %h", first_byte[7:0],
             png_bytes_q[skip].data);
      fail_count++;
    end
    if (cmd == 1'b0) frame_count++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (png_bytes_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic write_dim(logic reg_idx, logic [10:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {21'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_WIDTH) pr_width = v;
    else pr_height = v;
    @(posedge clk);
  endtask

  task automatic random_frame(int pixels);
    send_cmd(1'b0, $urandom, -1);
    for (int i = 0; i < pixels; i++) send_cmd(1'b1, $urandom, -1);
  endtask

  stim_row_t directed_rows[] = '{
    '{1'b1, 32'h12345678, -1},
    '{1'b0, 32'h0, 8'h89},
    '{1'b1, 32'hFFFFFFFF, 8'h01},
    '{1'b1, 32'h00000000, -1},
    '{1'b0, 32'hAAAAAAAA, 8'h89},
    '{1'b1, 32'h55555555, -1},
    '{1'b1, 32'hFF00FF00, -1},
    '{1'b1, 32'h00FF00FF, -1},
    '{1'b1, 32'h80808080, -1},
    '{1'b1, 32'h7F7F7F7F, -1}
  };

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 16;
    recv_stall_pct = 58;
    // width 0 and height 0 clamp to 1; pixel with no frame ignored
    write_dim(REG_WIDTH, 11'd0);
    write_dim(REG_HEIGHT, 11'd0);
    foreach (directed_rows[i]) begin
      if (i == 4) begin
        drain();
        write_dim(REG_WIDTH, 11'd2);
        write_dim(REG_HEIGHT, 11'd2);
      end
      send_cmd(directed_rows[i].cmd, directed_rows[i].argb, directed_rows[i].first_byte);
    end
    drain();
    // oversize clamps to maximum; abandoned by a new start
    write_dim(REG_WIDTH, 11'd2047);
    write_dim(REG_HEIGHT, 11'd2047);
    send_cmd(1'b0, 32'h0, 8'h89);
    for (int i = 0; i < 6; i++) send_cmd(1'b1, $urandom, -1);
    drain();
    write_dim(REG_WIDTH, 11'd1024);
    write_dim(REG_HEIGHT, 11'd1);
    send_cmd(1'b0, 32'h0, 8'h89);
    send_cmd(1'b1, 32'h01020304, -1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 16 : (ph == 1) ? 58 : 0;
      recv_stall_pct = (ph == 0) ? 58 : (ph == 1) ? 16 : 0;
      for (int f = 0; f < 8; f++) begin
        int unsigned w;
        int unsigned h;
        drain();
        w = $urandom_range(1, 5);
        h = $urandom_range(1, 4);
        write_dim(REG_WIDTH, 11'(w));
        write_dim(REG_HEIGHT, 11'(h));
        if ($urandom_range(9) == 0) random_frame($urandom_range(0, w * h - 1));
        else if ($urandom_range(9) == 0) send_cmd(1'b1, $urandom, -1);
        random_frame(w * h);
      end
    end
    drain();

    $display("Ran %0d frames, %0d bytes checked, sizes 1x1 up to 1024 wide.",
             frame_count, byte_count);
    if (fail_count == 0 && png_bytes_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
